@@ hw/rtl/window_coefficient_generator_defines.svh @@
// assertion macros shared by the checker
`ifndef WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH
`define WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define WCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define WCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/wcg_pkg.sv @@
// shared types, constants and tables of the window coefficient generator
package wcg_pkg;

  localparam int MAX_LENGTH     = 4096;
  localparam int COEF_FRAC_BITS = 15;
  localparam int IDX_W          = 12;
  localparam int LEN_W          = 13;
  localparam int KIND_W         = 2;
  localparam int COEF_W         = 16;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HANN     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HAMMING  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BLACKMAN = 2'd3;

  localparam logic CFG_KIND   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // phase divider: 33 quotient bits, three per stage
  localparam int Q_BITS     = 33;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = Q_BITS / DIV_STEPS;

  // cordic: 16 rotations, two per stage
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_PER    = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;
  localparam int CW            = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam int PW = 66;
  localparam int RND_SHIFT = 60 - COEF_FRAC_BITS;
  localparam int RW = PW - RND_SHIFT;
  localparam logic [RW-1:0] COEF_ONE = RW'(1) << COEF_FRAC_BITS;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              err;
  } meta_t;

  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } wcoef_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] v;
    unique case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004755;
      4:  v = 34'sd42667334;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679839;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q30 weights a0 - a1*cos(p) + a2*cos(2p)
  function automatic wcoef_t kind_coef(input logic [KIND_W-1:0] kind);
    wcoef_t c;
    unique case (kind)
      KIND_HANN:     c = '{32'sd536870912, 32'sd536870912, 32'sd0};
      KIND_HAMMING:  c = '{32'sd579820585, 32'sd493921239, 32'sd0};
      KIND_BLACKMAN: c = '{32'sd450971566, 32'sd536870912, 32'sd85899346};
      default:       c = '{32'sd0, 32'sd0, 32'sd0};
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/wcg_divider.sv @@
// pipelined restoring divider: phase index/length and twice it in 2^-32 turns
module wcg_divider import wcg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  meta_t            meta_in,
  input  logic [IDX_W-1:0] index,
  input  logic [LEN_W-1:0] len,
  output meta_t            meta_out,
  output logic [31:0]      phase1,
  output logic [31:0]      phase2
);

  meta_t             meta_q [DIV_STAGES];
  logic [LEN_W-1:0]  rem_q  [DIV_STAGES];
  logic [Q_BITS-1:0] quo_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    meta_t             m_in;
    logic [LEN_W-1:0]  r_in;
    logic [Q_BITS-1:0] q_in;
    logic [LEN_W-1:0]  r_next;
    logic [Q_BITS-1:0] q_next;
    logic [LEN_W:0]    t;

    if (s == 0) begin : g_first
      assign m_in = meta_in;
      assign r_in = {1'b0, index};
      assign q_in = '0;
    end else begin : g_rest
      assign m_in = meta_q[s-1];
      assign r_in = rem_q[s-1];
      assign q_in = quo_q[s-1];
    end

    always_comb begin
      r_next = r_in;
      q_next = q_in;
      t      = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {r_next, 1'b0};
        if (t >= {1'b0, len}) begin
          r_next = LEN_W'(t - {1'b0, len});
          q_next = {q_next[Q_BITS-2:0], 1'b1};
        end else begin
          r_next = t[LEN_W-1:0];
          q_next = {q_next[Q_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        meta_q[s] <= '0;
      end else if (en) begin
        meta_q[s] <= m_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= r_next;
        quo_q[s] <= q_next;
      end
    end
  end

  assign meta_out = meta_q[DIV_STAGES-1];
  assign phase1   = quo_q[DIV_STAGES-1][Q_BITS-1:1];
  assign phase2   = quo_q[DIV_STAGES-1][31:0];

endmodule

@@ hw/rtl/wcg_cordic.sv @@
// pipelined rotation-mode cordic cosine with quadrant folding
module wcg_cordic import wcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  meta_t                meta_in,
  input  logic [31:0]          phase,
  output meta_t                meta_out,
  output logic signed [CW-1:0] cos_x,
  output logic                 neg
);

  meta_t                meta_q [CORDIC_STAGES];
  logic signed [CW-1:0] x_q    [CORDIC_STAGES];
  logic signed [CW-1:0] y_q    [CORDIC_STAGES];
  logic signed [CW-1:0] z_q    [CORDIC_STAGES];
  logic                 neg_q  [CORDIC_STAGES];

  // fold the second and third quadrants by half a turn
  logic [31:0] ph_sum;
  logic        fold;
  logic [31:0] ph_fold;

  assign ph_sum  = phase + 32'h4000_0000;
  assign fold    = ph_sum[31];
  assign ph_fold = fold ? (phase + 32'h8000_0000) : phase;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    meta_t                m_in;
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic                 n_in;
    logic signed [CW-1:0] x_next, y_next, z_next, dx, dy;

    if (s == 0) begin : g_first
      assign m_in = meta_in;
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = $signed({{(CW-32){ph_fold[31]}}, ph_fold});
      assign n_in = fold;
    end else begin : g_rest
      assign m_in = meta_q[s-1];
      assign x_in = x_q[s-1];
      assign y_in = y_q[s-1];
      assign z_in = z_q[s-1];
      assign n_in = neg_q[s-1];
    end

    always_comb begin
      x_next = x_in;
      y_next = y_in;
      z_next = z_in;
      dx     = '0;
      dy     = '0;
      for (int j = 0; j < CORDIC_PER; j++) begin
        dx = y_next >>> (s * CORDIC_PER + j);
        dy = x_next >>> (s * CORDIC_PER + j);
        if (!z_next[CW-1]) begin
          x_next = x_next - dx;
          y_next = y_next + dy;
          z_next = z_next - atan_turn(s * CORDIC_PER + j);
        end else begin
          x_next = x_next + dx;
          y_next = y_next - dy;
          z_next = z_next + atan_turn(s * CORDIC_PER + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        meta_q[s] <= '0;
      end else if (en) begin
        meta_q[s] <= m_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[s]   <= x_next;
        y_q[s]   <= y_next;
        z_q[s]   <= z_next;
        neg_q[s] <= n_in;
      end
    end
  end

  assign meta_out = meta_q[CORDIC_STAGES-1];
  assign cos_x    = x_q[CORDIC_STAGES-1];
  assign neg      = neg_q[CORDIC_STAGES-1];

endmodule

@@ hw/rtl/wcg_combine.sv @@
// weighting multiplies, sum and round/clamp to q1.15
module wcg_combine import wcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  meta_t                meta_in,
  input  logic signed [CW-1:0] x1,
  input  logic                 neg1,
  input  logic signed [CW-1:0] x2,
  input  logic                 neg2,
  output logic                 coef_valid,
  output logic [COEF_W-1:0]    coefficient,
  output logic                 index_error
);

  logic signed [CW-1:0] c1, c2;
  wcoef_t               k_in, k_sum;
  meta_t                meta_m, meta_s;
  logic signed [PW-1:0] p1_q, p2_q, w_q;
  logic signed [PW-1:0] w_next;
  logic [RW-1:0]        r;
  logic [COEF_W-1:0]    coef_next;

  assign c1   = neg1 ? -x1 : x1;
  assign c2   = neg2 ? -x2 : x2;
  assign k_in = kind_coef(meta_in.kind);

  // multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      p1_q <= PW'(k_in.a1) * PW'(c1);
      p2_q <= PW'(k_in.a2) * PW'(c2);
    end
  end

  // sum stage
  assign k_sum  = kind_coef(meta_m.kind);
  assign w_next = (PW'(k_sum.a0) <<< 30) - p1_q + p2_q;

  always_ff @(posedge clk) begin
    if (en) begin
      w_q <= w_next;
    end
  end

  // round half up, clamp to one, zero for errors, kind none and sums <= 0
  always_comb begin
    r = RW'((w_q + (PW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT);
    if (meta_s.err || meta_s.kind == KIND_NONE || w_q <= 0) begin
      coef_next = '0;
    end else if (r > COEF_ONE) begin
      coef_next = COEF_W'(COEF_ONE);
    end else begin
      coef_next = COEF_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_m     <= '0;
      meta_s     <= '0;
      coef_valid <= 1'b0;
    end else if (en) begin
      meta_m     <= meta_in;
      meta_s     <= meta_m;
      coef_valid <= meta_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coefficient <= coef_next;
      index_error <= meta_s.err;
    end
  end

endmodule

@@ hw/rtl/window_coefficient_generator.sv @@
// top level of the periodic window coefficient generator
//
// request in: sample_valid / sample_stall with sample_index. a request is
// taken at a rising edge with sample_valid high and sample_stall low.
// request out: coef_valid / coef_stall with coefficient (unsigned q1.15,
// 32768 is 1.0) and index_error (index not below the window length).
// configuration: cfg_write with cfg_index 0 for window_kind, 1 for
// window_length; write only while no request is in flight.
// the pipeline has 11 divider stages (three quotient bits each), 8 cordic
// stages (two rotations each) and 3 stages for multiply, sum and rounding.
// throughput is one request per cycle unless coef_stall holds a result; the
// divider and cordic are fully pipelined and both cosines run in parallel.
// reset clears every valid bit and loads kind hann, length 1024.
// while coef_stall holds a waiting result the whole pipeline freezes and
// sample_stall goes high; nothing is lost or repeated.
module window_coefficient_generator import wcg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [IDX_W-1:0]  sample_index,
  output logic              coef_valid,
  input  logic              coef_stall,
  output logic [COEF_W-1:0] coefficient,
  output logic              index_error,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  logic [KIND_W-1:0] window_kind;
  logic [LEN_W-1:0]  window_length;
  logic [LEN_W-1:0]  len_eff;
  logic              en;
  meta_t             meta_in, meta_div, meta_cor;
  logic [31:0]       phase1, phase2;
  logic signed [CW-1:0] x1, x2;
  logic              neg1, neg2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind   <= KIND_HANN;
      window_length <= LEN_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KIND:   window_kind   <= cfg_data[KIND_W-1:0];
        CFG_LENGTH: window_length <= cfg_data;
        default:    ;
      endcase
    end
  end

  // lengths beyond the maximum act as the maximum
  assign len_eff = (window_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                        : window_length;

  // pipeline advances unless a finished result is held
  assign en           = !(coef_valid && coef_stall);
  assign sample_stall = !en;

  // range check up front, travels with the request
  assign meta_in.valid = sample_valid;
  assign meta_in.kind  = window_kind;
  assign meta_in.err   = (len_eff == '0) || ({1'b0, sample_index} >= len_eff);

  wcg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .meta_in  (meta_in),
    .index    (sample_index),
    .len      (len_eff),
    .meta_out (meta_div),
    .phase1   (phase1),
    .phase2   (phase2)
  );

  // first harmonic carries the request state
  wcg_cordic u_cos1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .meta_in  (meta_div),
    .phase    (phase1),
    .meta_out (meta_cor),
    .cos_x    (x1),
    .neg      (neg1)
  );

  // second harmonic, used by blackman only
  wcg_cordic u_cos2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .meta_in  ('0),
    .phase    (phase2),
    .meta_out (),
    .cos_x    (x2),
    .neg      (neg2)
  );

  wcg_combine u_comb (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .meta_in     (meta_cor),
    .x1          (x1),
    .neg1        (neg1),
    .x2          (x2),
    .neg2        (neg2),
    .coef_valid  (coef_valid),
    .coefficient (coefficient),
    .index_error (index_error)
  );

endmodule

@@ hw/rtl/wcg_checker.sv @@
// port-level checks of the window coefficient generator, bound to the top
`include "window_coefficient_generator_defines.svh"

module wcg_checker import wcg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic [IDX_W-1:0]  sample_index,
  input logic              coef_valid,
  input logic              coef_stall,
  input logic [COEF_W-1:0] coefficient,
  input logic              index_error,
  input logic              cfg_write,
  input logic              cfg_index,
  input logic [LEN_W-1:0]  cfg_data
);

  `WCG_ASSERT_NOW(a_err_zero, coef_valid && index_error, coefficient == '0, "error with nonzero coefficient")
  `WCG_ASSERT_NOW(a_range, coef_valid, coefficient <= COEF_W'(32768), "coefficient above one")
  `WCG_ASSERT_NOW(a_stall_back, coef_valid && coef_stall, sample_stall, "input open while output held")
  `WCG_ASSERT_NEXT(a_reset_idle, rst, !coef_valid, "result valid right after reset")

endmodule

bind window_coefficient_generator wcg_checker u_chk (.*);
